[src/tje_pkg.sv]
// Shared types, constants and helpers of the tricorn Julia escape-time block.
// Has no dependencies; every other file of the block uses it.
package tje_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int Z_W         = 32;
  localparam int PROD_W      = 64;
  localparam int MAG_W       = 36;
  localparam int PIX_W       = 10;
  localparam int OUT_COUNT_W = 16;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;

  // Escape threshold 4.0 in Q8.28.
  localparam logic [MAG_W-1:0] ESCAPE_MAG = 36'd4 << FRAC_BITS;

  localparam logic [15:0] MAX_ITER_RST = 16'd64;
  localparam logic [30:0] SCALE_RST    = 31'd262144;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER     = 3'd0,
    CFG_PIXEL_SCALE  = 3'd1,
    CFG_OFFSET_REAL  = 3'd2,
    CFG_OFFSET_IMAG  = 3'd3,
    CFG_C_REAL       = 3'd4,
    CFG_C_IMAG       = 3'd5
  } tje_cfg_idx_t;

  typedef struct packed {
    logic [15:0]        max_iterations;
    logic [30:0]        pixel_scale;
    logic signed [31:0] offset_real;
    logic signed [31:0] offset_imag;
    logic signed [30:0] c_real;
    logic signed [30:0] c_imag;
  } tje_cfg_t;

  typedef enum logic [2:0] {
    OP_DX_SCALE,
    OP_DY_SCALE,
    OP_RR,
    OP_II,
    OP_RI
  } tje_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_I,
    ST_SQ_I,
    ST_CROSS,
    ST_UPDATE,
    ST_SQ_R,
    ST_DONE
  } tje_state_t;

  typedef struct packed {
    tje_op_t op_sel;
    logic    ld_pix;
    logic    ld_zr_map;
    logic    ld_zi_map;
    logic    ld_rr;
    logic    ld_ii_mag;
    logic    ld_z_upd;
    logic    clr_count;
    logic    ld_out;
  } tje_ctrl_t;

  // Clamp a wide signed value to the signed 32-bit Q4.28 range.
  function automatic logic signed [Z_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [Z_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[Z_W-1:0]);
    end
    return r;
  endfunction

endpackage

[src/tje_pix_if.sv]
// Input channel of the escape-time block: one pixel coordinate per transfer.
// Depends on tje_pkg for the coordinate width.
interface tje_pix_if;
  logic                      valid;
  logic                      ready;
  logic [tje_pkg::PIX_W-1:0] pixel_x;
  logic [tje_pkg::PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[src/tje_res_if.sv]
// Result channel of the escape-time block: count, escape flag and final |z|^2.
// Depends on tje_pkg for the field widths.
interface tje_res_if;
  logic                            valid;
  logic                            ready;
  logic [tje_pkg::OUT_COUNT_W-1:0] iteration_count;
  logic                            escaped;
  logic [tje_pkg::MAG_W-1:0]       magnitude_squared;

  modport source (output valid, output iteration_count, output escaped,
                  output magnitude_squared, input ready);
  modport sink   (input valid, input iteration_count, input escaped,
                  input magnitude_squared, output ready);
endinterface

[src/tje_mul.sv]
// Shared signed 32 x 32 multiplier with a registered product.
// Depends on tje_pkg for the operand and product widths.
module tje_mul (
  input  logic                              clk,
  input  logic signed [tje_pkg::Z_W-1:0]    a,
  input  logic signed [tje_pkg::Z_W-1:0]    b,
  output logic signed [tje_pkg::PROD_W-1:0] product_r
);
  import tje_pkg::*;

  always_ff @(posedge clk) begin
    product_r <= a * b;
  end

endmodule

[src/tje_datapath.sv]
// Datapath: coordinate mapping, z registers, squares, update and escape test.
// Depends on tje_pkg and on tje_mul, the one multiplier that all steps share.
module tje_datapath #(
  parameter int IMAGE_SIZE  = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tje_pkg::tje_cfg_t                   cfg,
  input  tje_pkg::tje_ctrl_t                  ctl,
  input  logic [tje_pkg::PIX_W-1:0]           pixel_x,
  input  logic [tje_pkg::PIX_W-1:0]           pixel_y,
  output logic                                finish,
  output logic [tje_pkg::OUT_COUNT_W-1:0]     iteration_count,
  output logic                                escaped,
  output logic [tje_pkg::MAG_W-1:0]           magnitude_squared
);
  import tje_pkg::*;

  localparam logic signed [Z_W-1:0] HALF = 32'(IMAGE_SIZE / 2);

  logic [PIX_W-1:0]           px_r, py_r;
  logic signed [Z_W-1:0]      zr_r, zi_r;
  logic signed [PROD_W-1:0]   rr_r, ii_r;
  logic [MAG_W-1:0]           mag_r;
  logic [COUNT_WIDTH-1:0]     count_r, limit;
  logic [OUT_COUNT_W-1:0]     iter_out_r;
  logic                       escaped_r;
  logic [MAG_W-1:0]           mag_out_r;

  logic signed [Z_W-1:0]      op_a, op_b, dx, dy;
  logic signed [PROD_W-1:0]   product_r;

  logic signed [49:0]         t_ext, t3, re_map;
  logic signed [65:0]         im_map, sq, neg_cross;
  logic signed [Z_W-1:0]      zr_map, zi_map, zr_new, zi_new;
  logic [PROD_W:0]            mag_sum;
  logic [MAG_W-1:0]           mag_now;

  tje_mul u_mul (
    .clk       (clk),
    .a         (op_a),
    .b         (op_b),
    .product_r (product_r)
  );

  assign dx = $signed(32'(px_r)) - HALF;
  assign dy = $signed(32'(py_r)) - HALF;

  always_comb begin
    case (ctl.op_sel)
      OP_DX_SCALE: begin
        op_a = dx;
        op_b = $signed({1'b0, cfg.pixel_scale});
      end
      OP_DY_SCALE: begin
        op_a = dy;
        op_b = $signed({1'b0, cfg.pixel_scale});
      end
      OP_RR: begin
        op_a = zr_r;
        op_b = zr_r;
      end
      OP_II: begin
        op_a = zi_r;
        op_b = zi_r;
      end
      OP_RI: begin
        op_a = zr_r;
        op_b = zi_r;
      end
      default: begin
        op_a = zr_r;
        op_b = zr_r;
      end
    endcase
  end

  // Start point: the real part is floor(-3t/2) - offset, t = (x - W/2) * scale.
  always_comb begin
    t_ext  = $signed(product_r[49:0]);
    t3     = -(t_ext + (t_ext <<< 1));
    re_map = (t3 >>> 1) - $signed({{18{cfg.offset_real[31]}}, cfg.offset_real});
    zr_map = sat32($signed({{16{re_map[49]}}, re_map}));
    im_map = $signed({{2{product_r[PROD_W-1]}}, product_r}) +
             $signed({{34{cfg.offset_imag[31]}}, cfg.offset_imag});
    zi_map = sat32(im_map);
  end

  // Map step: the product register holds zr*zi while rr_r and ii_r hold the squares.
  always_comb begin
    sq        = $signed({{2{rr_r[PROD_W-1]}}, rr_r}) - $signed({{2{ii_r[PROD_W-1]}}, ii_r});
    zr_new    = sat32((sq >>> FRAC_BITS) + $signed({{35{cfg.c_real[30]}}, cfg.c_real}));
    neg_cross = -$signed({{2{product_r[PROD_W-1]}}, product_r});
    zi_new    = sat32((neg_cross >>> (FRAC_BITS - 1)) +
                      $signed({{35{cfg.c_imag[30]}}, cfg.c_imag}));
  end

  // Escape test, valid while the product register holds zi^2.
  always_comb begin
    mag_sum = {1'b0, rr_r} + {1'b0, product_r};
    mag_now = mag_sum[PROD_W] ? {MAG_W{1'b1}} : mag_sum[MAG_W+FRAC_BITS-1:FRAC_BITS];
    limit   = COUNT_WIDTH'(cfg.max_iterations);
    finish  = (mag_now >= ESCAPE_MAG) || (count_r >= limit);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_pix) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
    end
    if (ctl.ld_zr_map) begin
      zr_r <= zr_map;
    end else if (ctl.ld_z_upd) begin
      zr_r <= zr_new;
    end
    if (ctl.ld_zi_map) begin
      zi_r <= zi_map;
    end else if (ctl.ld_z_upd) begin
      zi_r <= zi_new;
    end
    if (ctl.ld_rr) begin
      rr_r <= product_r;
    end
    if (ctl.ld_ii_mag) begin
      ii_r  <= product_r;
      mag_r <= mag_now;
    end
    if (ctl.ld_out) begin
      iter_out_r <= OUT_COUNT_W'(count_r);
      escaped_r  <= (count_r < limit);
      mag_out_r  <= mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clr_count) begin
      count_r <= '0;
    end else if (ctl.ld_z_upd) begin
      count_r <= count_r + 1'b1;
    end
  end

  assign iteration_count   = iter_out_r;
  assign escaped           = escaped_r;
  assign magnitude_squared = mag_out_r;

endmodule

[src/tje_ctrl.sv]
// Sequencer that steps the shared multiplier through mapping and map iterations.
// Depends on tje_pkg for the state, operation and control types.
module tje_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               finish,
  output tje_pkg::tje_ctrl_t ctl
);
  import tje_pkg::*;

  tje_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    ctl.op_sel    = OP_RR;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.ld_pix = in_valid;
        if (in_valid) begin
          state_nxt = ST_MAP_X;
        end
      end
      ST_MAP_X: begin
        ctl.op_sel = OP_DX_SCALE;
        state_nxt  = ST_MAP_Y;
      end
      ST_MAP_Y: begin
        ctl.op_sel    = OP_DY_SCALE;
        ctl.ld_zr_map = 1'b1;
        ctl.clr_count = 1'b1;
        state_nxt     = ST_MAP_I;
      end
      ST_MAP_I: begin
        ctl.op_sel    = OP_RR;
        ctl.ld_zi_map = 1'b1;
        state_nxt     = ST_SQ_I;
      end
      ST_SQ_R: begin
        ctl.op_sel = OP_RR;
        state_nxt  = ST_SQ_I;
      end
      ST_SQ_I: begin
        ctl.op_sel = OP_II;
        ctl.ld_rr  = 1'b1;
        state_nxt  = ST_CROSS;
      end
      ST_CROSS: begin
        ctl.op_sel    = OP_RI;
        ctl.ld_ii_mag = 1'b1;
        state_nxt     = finish ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl.ld_z_upd = 1'b1;
        state_nxt    = ST_SQ_R;
      end
      ST_DONE: begin
        // Wait here while the previous result has not been transferred.
        if (!out_valid_r || out_ready) begin
          ctl.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_out |-> (!out_valid_r || out_ready))
    else $error("result register loaded while holding an untransferred result");

  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_out |=> (out_valid_r && in_ready))
    else $error("result not presented or input not reopened after completion");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MAP_X && !in_ready))
    else $error("accepted pixel did not start the mapping sequence");

  a_loads_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.ld_out, ctl.ld_z_upd, ctl.ld_zr_map, ctl.ld_zi_map, ctl.ld_rr}))
    else $error("conflicting datapath load strobes");

endmodule

[src/tricorn_julia_escape_time.sv]
// Tricorn Julia escape-time evaluator, one pixel coordinate in, one result out.
// The input channel in_pix transfers (pixel_x, pixel_y); the result channel
// out_res transfers iteration_count, escaped and magnitude_squared (Q8.28).
// The configuration port writes one register per cycle with cfg_we high;
// cfg_index selects max_iterations, pixel_scale, offset_real, offset_imag,
// c_real or c_imag in that order. Write it only while no pixel is in flight.
// One signed 32 x 32 multiplier, registered, is shared by every step: the
// start point is mapped in ST_MAP_X, ST_MAP_Y and ST_MAP_I, and each map
// iteration runs zr^2, zi^2, zr*zi with the escape test, then the update.
// in_pix.ready is high only between pixels, so a new pixel is taken only
// after the last one has finished.
// The result sits in an output register; a new pixel is taken while it waits.
// If the receiver stalls, a finished pixel waits for the register to drain.
// Reset (rst_n low at a clock edge) returns to idle, drops a pending result
// and restores the register defaults (limit 64, scale 2^-10, c and offsets 0).
// Depends on tje_pkg, tje_pix_if, tje_res_if, tje_ctrl and tje_datapath.
module tricorn_julia_escape_time #(
  parameter int IMAGE_SIZE  = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tje_pix_if.sink                         in_pix,
  tje_res_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [tje_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tje_pkg::CFG_W-1:0]       cfg_wdata
);
  import tje_pkg::*;

  tje_cfg_t  cfg_r;
  tje_ctrl_t ctl;
  logic      finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iterations <= MAX_ITER_RST;
      cfg_r.pixel_scale    <= SCALE_RST;
      cfg_r.offset_real    <= '0;
      cfg_r.offset_imag    <= '0;
      cfg_r.c_real         <= '0;
      cfg_r.c_imag         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ITER:    cfg_r.max_iterations <= cfg_wdata[15:0];
        CFG_PIXEL_SCALE: cfg_r.pixel_scale    <= cfg_wdata[30:0];
        CFG_OFFSET_REAL: cfg_r.offset_real    <= $signed(cfg_wdata);
        CFG_OFFSET_IMAG: cfg_r.offset_imag    <= $signed(cfg_wdata);
        CFG_C_REAL:      cfg_r.c_real         <= $signed(cfg_wdata[30:0]);
        CFG_C_IMAG:      cfg_r.c_imag         <= $signed(cfg_wdata[30:0]);
        default: begin
        end
      endcase
    end
  end

  tje_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .finish    (finish),
    .ctl       (ctl)
  );

  tje_datapath #(
    .IMAGE_SIZE  (IMAGE_SIZE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .ctl               (ctl),
    .pixel_x           (in_pix.pixel_x),
    .pixel_y           (in_pix.pixel_y),
    .finish            (finish),
    .iteration_count   (out_res.iteration_count),
    .escaped           (out_res.escaped),
    .magnitude_squared (out_res.magnitude_squared)
  );

endmodule

[tb/tje_escape_check.sv]
// Result checker for the tricorn Julia escape-time block: watches the pixel, result and
// register-write ports, predicts each pixel's result and compares it on arrival.
// Depends on tje_pkg, tje_pix_if and tje_res_if.
`timescale 1ns / 100ps

module tje_escape_check #(
  parameter int IMAGE_SIZE  = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tje_pix_if                            pix_mon,
  tje_res_if                            res_mon,
  input  logic                          cfg_we,
  input  logic [tje_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tje_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            mismatches,
  output int                            pending,
  output int                            checked,
  output int                            escapes
);
  import tje_pkg::*;

  typedef struct packed {
    logic [15:0] count;
    logic        escaped;
    logic [35:0] mag;
  } escape_res_t;

  localparam longint HALF_SPAN = IMAGE_SIZE / 2;
  localparam longint Q428_MAX  = 64'sd2147483647;
  localparam longint Q428_MIN  = -64'sd2147483648;
  localparam longint unsigned MAG_SAT = (64'd1 << 36) - 64'd1;
  localparam longint unsigned ESC_MAG = 64'd4 << 28;

  tje_cfg_t    view;
  escape_res_t pixel_results_q[$];
  int          errs = 0;
  int          n_checked = 0;
  int          n_escaped = 0;

  function automatic longint clamp_q428(input longint v);
    if (v > Q428_MAX) return Q428_MAX;
    if (v < Q428_MIN) return Q428_MIN;
    return v;
  endfunction

  // Squares are exact in 64 bits; only their sum needs unsigned room.
  function automatic longint unsigned mag_q828(input longint zr, input longint zi);
    longint unsigned sq_r;
    longint unsigned sq_i;
    longint unsigned sum;
    sq_r = zr * zr;
    sq_i = zi * zi;
    sum = (sq_r + sq_i) >> 28;
    return (sum > MAG_SAT) ? MAG_SAT : sum;
  endfunction

  function automatic escape_res_t escape_time(input logic [PIX_W-1:0] px,
                                              input logic [PIX_W-1:0] py,
                                              input tje_cfg_t s);
    longint          span;
    longint          zr;
    longint          zi;
    longint          nr;
    longint          ni;
    longint unsigned mag;
    longint unsigned limit;
    longint unsigned steps;
    escape_res_t     r;
    span = (longint'(px) - HALF_SPAN) * longint'(s.pixel_scale);
    // Arithmetic right shifts on signed values round toward minus infinity.
    zr = clamp_q428(((-3 * span) >>> 1) - longint'($signed(s.offset_real)));
    zi = clamp_q428((longint'(py) - HALF_SPAN) * longint'(s.pixel_scale)
                    + longint'($signed(s.offset_imag)));
    limit = longint'(s.max_iterations) & ((64'd1 << COUNT_WIDTH) - 64'd1);
    steps = 0;
    mag = mag_q828(zr, zi);
    while (mag < ESC_MAG && steps < limit) begin
      nr = clamp_q428(((zr * zr - zi * zi) >>> 28) + longint'($signed(s.c_real)));
      ni = clamp_q428(((-(zr * zi)) >>> 27) + longint'($signed(s.c_imag)));
      zr = nr;
      zi = ni;
      steps++;
      mag = mag_q828(zr, zi);
    end
    r.count   = steps[15:0];
    r.escaped = (steps < limit);
    r.mag     = mag[35:0];
    return r;
  endfunction

  always @(posedge clk) begin
    escape_res_t want;
    if (!rst_n) begin
      pixel_results_q.delete();
      view = '{MAX_ITER_RST, SCALE_RST, 32'sd0, 32'sd0, 31'sd0, 31'sd0};
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (pixel_results_q.size() == 0) begin
          $error("result transfer with no pixel outstanding: iteration_count %0d",
                 res_mon.iteration_count);
          errs++;
        end else begin
          want = pixel_results_q.pop_front();
          n_checked++;
          if (want.escaped) n_escaped++;
          if (res_mon.iteration_count !== want.count) begin
            $error("iteration_count: expected %0d, got %0d", want.count,
                   res_mon.iteration_count);
            errs++;
          end
          if (res_mon.escaped !== want.escaped) begin
            $error("escaped: expected %0d, got %0d", want.escaped, res_mon.escaped);
            errs++;
          end
          if (res_mon.magnitude_squared !== want.mag) begin
            $error("magnitude_squared: expected 0x%09h, got 0x%09h", want.mag,
                   res_mon.magnitude_squared);
            errs++;
          end
        end
      end
      if (pix_mon.valid && pix_mon.ready) begin
        pixel_results_q.push_back(escape_time(pix_mon.pixel_x, pix_mon.pixel_y, view));
      end
      if (cfg_we) begin
        case (tje_cfg_idx_t'(cfg_index))
          CFG_MAX_ITER:    view.max_iterations = cfg_wdata[15:0];
          CFG_PIXEL_SCALE: view.pixel_scale    = cfg_wdata[30:0];
          CFG_OFFSET_REAL: view.offset_real    = cfg_wdata;
          CFG_OFFSET_IMAG: view.offset_imag    = cfg_wdata;
          CFG_C_REAL:      view.c_real         = cfg_wdata[30:0];
          CFG_C_IMAG:      view.c_imag         = cfg_wdata[30:0];
          default: ;
        endcase
      end
    end
    pending    <= pixel_results_q.size();
    mismatches <= errs;
    checked    <= n_checked;
    escapes    <= n_escaped;
  end

endmodule

[tb/tb_tricorn_julia_escape_time.sv]
// Top of the escape-time testbench: clock, reset, pixel and register stimulus, result
// back-pressure and the verdict. Depends on tje_pkg, both channel interfaces,
// tje_escape_check and the tricorn_julia_escape_time block.
`timescale 1ns / 100ps

module tb_tricorn_julia_escape_time;
  import tje_pkg::*;

  localparam int IMAGE_SIZE      = 1024;
  localparam int COUNT_WIDTH     = 16;
  localparam int HALF_PERIOD     = 5;
  localparam int TIMEOUT_CYCLES  = 5_000_000;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 100;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 100;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int pixels_sent = 0;
  int settings_used = 0;

  int mismatches;
  int pending;
  int checked;
  int escapes;

  tje_pix_if pix_ch ();
  tje_res_if res_ch ();

  tricorn_julia_escape_time #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  tje_escape_check #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_escape_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_mon   (pix_ch),
    .res_mon   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending),
    .checked   (checked),
    .escapes   (escapes)
  );

  always #HALF_PERIOD clk = ~clk;

  // Writes all six registers back to back; the block must be idle.
  task automatic apply_settings(input tje_cfg_t s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ITER;
    cfg_wdata <= {16'd0, s.max_iterations};
    @(posedge clk);
    cfg_index <= CFG_PIXEL_SCALE;
    cfg_wdata <= {1'b0, s.pixel_scale};
    @(posedge clk);
    cfg_index <= CFG_OFFSET_REAL;
    cfg_wdata <= s.offset_real;
    @(posedge clk);
    cfg_index <= CFG_OFFSET_IMAG;
    cfg_wdata <= s.offset_imag;
    @(posedge clk);
    cfg_index <= CFG_C_REAL;
    cfg_wdata <= {s.c_real[30], s.c_real};
    @(posedge clk);
    cfg_index <= CFG_C_IMAG;
    cfg_wdata <= {s.c_imag[30], s.c_imag};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.pixel_x <= x;
    pix_ch.pixel_y <= y;
    do @(posedge clk); while (!pix_ch.ready);
    pixels_sent++;
  endtask

  // The checker's count is registered, so look only after the next edge.
  task automatic drain_pixels();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random signed value within plus or minus one in Q4.28.
  function automatic logic signed [31:0] near_unit();
    return $signed(32'($urandom_range(0, 1 << 29))) - 32'sd268435456;
  endfunction

  function automatic logic signed [30:0] pick_julia_c();
    logic signed [30:0] v;
    case ($urandom_range(0, 5))
      0: v = ($urandom_range(0, 1) != 0) ? 31'sd536870912 : -31'sd536870912;
      1: v = 31'($urandom());
      default: v = $signed(31'($urandom_range(0, 1 << 29))) - 31'sd268435456;
    endcase
    return v;
  endfunction

  function automatic tje_cfg_t random_view();
    tje_cfg_t s;
    case ($urandom_range(0, 7))
      0: s.max_iterations = 16'd1;
      1: s.max_iterations = 16'($urandom_range(2, 16));
      6: s.max_iterations = 16'($urandom_range(65, 128));
      default: s.max_iterations = 16'($urandom_range(17, 64));
    endcase
    case ($urandom_range(0, 5))
      0: s.pixel_scale = 31'($urandom_range(1, 1 << 17));
      1: s.pixel_scale = 31'($urandom());
      default: s.pixel_scale = 31'($urandom_range(1 << 17, 1 << 21));
    endcase
    s.offset_real = ($urandom_range(0, 3) == 0) ? $signed($urandom()) : near_unit();
    s.offset_imag = ($urandom_range(0, 3) == 0) ? $signed($urandom()) : near_unit();
    s.c_real      = pick_julia_c();
    s.c_imag      = pick_julia_c();
    return s;
  endfunction

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin : result_drain
    int stall_len;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        res_ch.ready <= 1'b0;
        stall_len = $urandom_range(1, 19);
        repeat (stall_len) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Timed out with %0d results outstanding.", pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    tje_cfg_t view;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    pix_ch.valid   = 1'b0;
    pix_ch.pixel_x = '0;
    pix_ch.pixel_y = '0;
    res_ch.ready   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: corners, and the center, which sits at zero and never escapes.
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd511, 10'd513);
    drain_pixels();

    // Zero limit: no iteration runs, the start magnitude comes back.
    apply_settings('{16'd0, SCALE_RST, 32'sd0, 32'sd0, 31'sd0, 31'sd0});
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    drain_pixels();

    // Widest scale and extreme offsets: the start point saturates and is already outside.
    apply_settings('{16'd1, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     31'sd536870912, -31'sd536870912});
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    drain_pixels();

    // Largest limit with c = 2 exactly: the center lands on |z|^2 = 4 after one step.
    apply_settings('{16'hFFFF, 31'h7FFF_FFFF, 32'sd0, 32'sd0, 31'sd536870912, 31'sd0});
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd513, 10'd512);
    send_pixel(10'd0, 10'd1023);
    drain_pixels();

    // Julia constant at both ends of its 31-bit range and offsets at the opposite extremes.
    apply_settings('{16'd16, 31'd1048576, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     31'sh4000_0000, 31'sh3FFF_FFFF});
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd300, 10'd700);
    drain_pixels();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      view = random_view();
      if (phase == 2) view.max_iterations = 16'd8;
      if (phase == RAND_PHASES - 1) idle_on = 1'b0;
      apply_settings(view);
      if (phase == 2) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      end
      drain_pixels();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d pixels under %0d register settings, with one long result hold-off.",
             pixels_sent, settings_used + 1);
    $display("Compared %0d results, %0d of them escaped; %0d mismatches.", checked, escapes,
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
